FILE: design/ess_pkg.sv
// Shared types and constants for the exponential sine sweep generator.
// Holds the sequencer state type, register indexes and sine table helpers.
// No dependencies.
package ess_pkg;

    localparam logic [63:0] Q48_ONE     = 64'h0001_0000_0000_0000;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1847;

    localparam logic [2:0] CFG_START_SCALE = 3'd0;
    localparam logic [2:0] CFG_GROWTH      = 3'd1;
    localparam logic [2:0] CFG_SWEEP_LEN   = 3'd2;
    localparam logic [2:0] CFG_FADE_LEN    = 3'd3;
    localparam logic [2:0] CFG_FADE_EN     = 3'd4;
    localparam logic [2:0] CFG_DEPTH_MODE  = 3'd5;

    localparam logic [1:0] MODE_16     = 2'd0;
    localparam logic [1:0] MODE_24     = 2'd1;
    localparam logic [1:0] MODE_32     = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_MUL,
        S_PHASE,
        S_ADDR,
        S_ROM,
        S_SCALE,
        S_FIN,
        S_DSET,
        S_DIV,
        S_FOUT,
        S_QST,
        S_QUPD,
        S_OUT
    } t_state;

    // Q2.60 multiply, truncating.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Taylor series up to x^19 in Q2.60, rounded half up to Q1.31.
    function automatic logic [31:0] sine_q31(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] x2;
        logic [63:0] r;
        sum  = x;
        term = x;
        x2   = mul_q60(x, x);
        term = mul_q60(term, x2) / 64'd6;
        sum  = sum - term;
        term = mul_q60(term, x2) / 64'd20;
        sum  = sum + term;
        term = mul_q60(term, x2) / 64'd42;
        sum  = sum - term;
        term = mul_q60(term, x2) / 64'd72;
        sum  = sum + term;
        term = mul_q60(term, x2) / 64'd110;
        sum  = sum - term;
        term = mul_q60(term, x2) / 64'd156;
        sum  = sum + term;
        term = mul_q60(term, x2) / 64'd210;
        sum  = sum - term;
        term = mul_q60(term, x2) / 64'd272;
        sum  = sum + term;
        term = mul_q60(term, x2) / 64'd342;
        sum  = sum - term;
        r = (sum + 64'h1000_0000) >> 29;
        if (r > 64'h8000_0000) begin
            r = 64'h8000_0000;
        end
        return r[31:0];
    endfunction

endpackage

FILE: design/exponential_sine_sweep_generator.sv
// Exponential sine sweep generator: one sweep sample per input request.
// Uses ess_pkg for the state type, register indexes and sine table helpers.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   i_s_tvalid / o_s_tready   tdata[0] restart
// m_axis    out  o_m_tvalid / i_m_tready   tdata sample, tlast last, tuser done_res
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// After acceptance a request keeps the input side busy until its result enters
// the output register; a request after the sweep ended skips the arithmetic. Each
// 64x64 product runs as four passes of one 32x32 multiplier plus a final
// accumulate, and each fade division as 64 restoring steps.
// Reset is synchronous, active low; it restores config, state, index and q = 1.0.
// The input side is not ready while a request is in work; a held result blocks
// only the final transfer into the output register.
module exponential_sine_sweep_generator #(
    parameter int INDEX_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] restart, [7:1] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] sample
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // [0] done_res
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int OFFW = INDEX_BITS - 2;
    localparam logic [63:0] DEPTH64 = 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] ROM_QH  = ess_pkg::HALF_PI_Q60 / DEPTH64;
    localparam logic [63:0] ROM_RM  = ess_pkg::HALF_PI_Q60 % DEPTH64;

    typedef logic [31:0] t_rom [0:SINE_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom        t;
        logic [63:0] kk;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            kk   = 64'(k);
            t[k] = ess_pkg::sine_q31(ROM_QH * kk + (ROM_RM * kk) / DEPTH64);
        end
        return t;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // configuration
    logic [63:0] r_start_scale;
    logic [63:0] r_growth;
    logic [24:0] r_sweep_len;
    logic [18:0] r_fade_len;
    logic        r_fade_en;
    logic [1:0]  r_depth_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_scale <= '0;
            r_growth      <= ess_pkg::Q48_ONE;
            r_sweep_len   <= 25'd48000;
            r_fade_len    <= 19'd960;
            r_fade_en     <= 1'b0;
            r_depth_mode  <= ess_pkg::MODE_16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ess_pkg::CFG_START_SCALE: r_start_scale <= i_cfg_data;
                ess_pkg::CFG_GROWTH:      r_growth      <= i_cfg_data;
                ess_pkg::CFG_SWEEP_LEN:   r_sweep_len   <= i_cfg_data[24:0];
                ess_pkg::CFG_FADE_LEN:    r_fade_len    <= i_cfg_data[18:0];
                ess_pkg::CFG_FADE_EN:     r_fade_en     <= i_cfg_data[0];
                ess_pkg::CFG_DEPTH_MODE:  r_depth_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    ess_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [63:0]  r_q, n_q;
    logic [24:0]  r_idx, n_idx;
    logic [63:0]  r_ma, n_ma, r_mb, n_mb;
    logic [2:0]   r_mcnt, n_mcnt;
    logic [63:0]  r_prod, n_prod;
    logic [1:0]   r_psh, n_psh;
    logic [127:0] r_acc, n_acc;
    logic         r_neg, n_neg;
    logic [1:0]   r_quad, n_quad;
    logic [AW-1:0] r_addr, n_addr;
    logic [31:0]  r_rom;
    logic [31:0]  r_mag, n_mag;
    logic [63:0]  r_dq, n_dq;
    logic [19:0]  r_rem, n_rem;
    logic [5:0]   r_dcnt, n_dcnt;
    logic         r_fout, n_fout;
    logic [31:0]  r_res, n_res;
    logic         r_rlast, n_rlast, r_rdone, n_rdone;
    logic         r_ovalid, n_ovalid;
    logic [31:0]  r_osample, n_osample;
    logic         r_olast, n_olast, r_odone, n_odone;

    logic         fade_on;
    logic [31:0]  pa, pb;
    logic [127:0] add_term;
    logic [127:0] pval;
    logic [31:0]  frac;
    logic [INDEX_BITS-1:0] pt;
    logic [OFFW:0] off;
    logic [63:0]  ashift;
    logic [31:0]  smag;
    logic [31:0]  smax;
    logic [19:0]  rem_sh;
    logic [63:0]  dq_new;
    logic [25:0]  idx_f;

    always_ff @(posedge i_clk) begin
        r_rom <= SINE_ROM[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ess_pkg::S_IDLE;
            r_ret    <= ess_pkg::S_IDLE;
            r_q      <= ess_pkg::Q48_ONE;
            r_idx    <= '0;
            r_mcnt   <= '0;
            r_dcnt   <= '0;
            r_fout   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_q      <= n_q;
            r_idx    <= n_idx;
            r_mcnt   <= n_mcnt;
            r_dcnt   <= n_dcnt;
            r_fout   <= n_fout;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_prod    <= n_prod;
        r_psh     <= n_psh;
        r_acc     <= n_acc;
        r_neg     <= n_neg;
        r_quad    <= n_quad;
        r_addr    <= n_addr;
        r_mag     <= n_mag;
        r_dq      <= n_dq;
        r_rem     <= n_rem;
        r_res     <= n_res;
        r_rlast   <= n_rlast;
        r_rdone   <= n_rdone;
        r_osample <= n_osample;
        r_olast   <= n_olast;
        r_odone   <= n_odone;
    end

    assign o_s_tready = (r_state == ess_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_osample;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_odone;

    assign fade_on = r_fade_en && (r_fade_len != 19'd0);
    assign idx_f   = {1'b0, r_idx} + {7'd0, r_fade_len};

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_q       = r_q;
        n_idx     = r_idx;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_mcnt    = r_mcnt;
        n_prod    = r_prod;
        n_psh     = r_psh;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_quad    = r_quad;
        n_addr    = r_addr;
        n_mag     = r_mag;
        n_dq      = r_dq;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_fout    = r_fout;
        n_res     = r_res;
        n_rlast   = r_rlast;
        n_rdone   = r_rdone;
        n_osample = r_osample;
        n_olast   = r_olast;
        n_odone   = r_odone;
        n_ovalid  = r_ovalid && !i_m_tready;

        pa       = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
        pb       = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
        case (r_psh)
            2'd0:    add_term = {64'd0, r_prod};
            2'd1:    add_term = {32'd0, r_prod, 32'd0};
            default: add_term = {r_prod, 64'd0};
        endcase
        // top 32 fraction bits of the Q56.72 phase
        pval     = r_neg ? (~r_acc + 128'd1) : r_acc;
        frac     = pval[71:40];
        pt       = frac[31 -: INDEX_BITS];
        off      = {1'b0, pt[OFFW-1:0]};
        if (pt[OFFW]) begin
            off = {1'b1, {OFFW{1'b0}}} - off;
        end
        ashift   = r_acc[63:0] >> OFFW;
        case (r_depth_mode)
            ess_pkg::MODE_16: begin
                smag = r_rom >> 16;
                smax = 32'h0000_7FFF;
            end
            ess_pkg::MODE_24: begin
                smag = r_rom >> 8;
                smax = 32'h007F_FFFF;
            end
            default: begin
                smag = r_rom;
                smax = 32'h7FFF_FFFF;
            end
        endcase
        rem_sh   = {r_rem[18:0], r_dq[63]};
        dq_new   = {r_dq[62:0], 1'b0};

        case (r_state)
            ess_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tdata[0]) begin
                        n_q   = ess_pkg::Q48_ONE;
                        n_idx = '0;
                    end
                    n_state = ess_pkg::S_CHK;
                end
            end
            ess_pkg::S_CHK: begin
                if (r_idx >= r_sweep_len) begin
                    n_res   = '0;
                    n_rlast = 1'b0;
                    n_rdone = 1'b1;
                    n_state = ess_pkg::S_OUT;
                end else begin
                    n_neg   = r_q < ess_pkg::Q48_ONE;
                    n_ma    = r_start_scale;
                    n_mb    = n_neg ? (ess_pkg::Q48_ONE - r_q) : (r_q - ess_pkg::Q48_ONE);
                    n_acc   = '0;
                    n_mcnt  = '0;
                    n_ret   = ess_pkg::S_PHASE;
                    n_state = ess_pkg::S_MUL;
                end
            end
            ess_pkg::S_MUL: begin
                // issue one partial product, accumulate the previous one
                n_prod = {32'd0, pa} * {32'd0, pb};
                n_psh  = {1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]};
                if (r_mcnt != 3'd0) begin
                    n_acc = r_acc + add_term;
                end
                n_mcnt = r_mcnt + 3'd1;
                if (r_mcnt == 3'd4) begin
                    n_state = r_ret;
                end
            end
            ess_pkg::S_PHASE: begin
                n_quad  = pt[INDEX_BITS-1 -: 2];
                n_ma    = 64'(off);
                n_mb    = DEPTH64;
                n_neg   = 1'b0;
                n_acc   = '0;
                n_mcnt  = '0;
                n_ret   = ess_pkg::S_ADDR;
                n_state = ess_pkg::S_MUL;
            end
            ess_pkg::S_ADDR: begin
                if (ashift > DEPTH64) begin
                    n_addr = AW'(SINE_TABLE_DEPTH);
                end else begin
                    n_addr = ashift[AW-1:0];
                end
                n_state = ess_pkg::S_ROM;
            end
            ess_pkg::S_ROM: begin
                n_state = ess_pkg::S_SCALE;
            end
            ess_pkg::S_SCALE: begin
                n_mag   = (smag > smax) ? smax : smag;
                n_state = ess_pkg::S_FIN;
            end
            ess_pkg::S_FIN: begin
                n_fout = 1'b0;
                if (fade_on && (r_idx < {6'd0, r_fade_len})) begin
                    n_ma    = {32'd0, r_mag};
                    n_mb    = {39'd0, r_idx};
                    n_acc   = '0;
                    n_mcnt  = '0;
                    n_ret   = ess_pkg::S_DSET;
                    n_state = ess_pkg::S_MUL;
                end else begin
                    n_state = ess_pkg::S_FOUT;
                end
            end
            ess_pkg::S_DSET: begin
                n_dq    = r_acc[63:0];
                n_rem   = '0;
                n_dcnt  = '0;
                n_state = ess_pkg::S_DIV;
            end
            ess_pkg::S_DIV: begin
                // one restoring division step
                if (rem_sh >= {1'b0, r_fade_len}) begin
                    n_rem     = rem_sh - {1'b0, r_fade_len};
                    dq_new[0] = 1'b1;
                end else begin
                    n_rem = rem_sh;
                end
                n_dq   = dq_new;
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) begin
                    n_mag   = dq_new[31:0];
                    n_state = r_fout ? ess_pkg::S_QST : ess_pkg::S_FOUT;
                end
            end
            ess_pkg::S_FOUT: begin
                if (fade_on && (idx_f >= {1'b0, r_sweep_len})) begin
                    n_fout  = 1'b1;
                    n_ma    = {32'd0, r_mag};
                    n_mb    = {39'd0, r_sweep_len - 25'd1 - r_idx};
                    n_acc   = '0;
                    n_mcnt  = '0;
                    n_ret   = ess_pkg::S_DSET;
                    n_state = ess_pkg::S_MUL;
                end else begin
                    n_state = ess_pkg::S_QST;
                end
            end
            ess_pkg::S_QST: begin
                n_res   = r_quad[1] ? (32'd0 - r_mag) : r_mag;
                n_rlast = (r_idx == r_sweep_len - 25'd1);
                n_rdone = 1'b0;
                n_ma    = r_q;
                n_mb    = r_growth;
                n_acc   = '0;
                n_mcnt  = '0;
                n_ret   = ess_pkg::S_QUPD;
                n_state = ess_pkg::S_MUL;
            end
            ess_pkg::S_QUPD: begin
                // saturate q on overflow of the Q16.48 range
                if (r_acc[127:112] != 16'd0) begin
                    n_q = '1;
                end else begin
                    n_q = r_acc[111:48];
                end
                n_idx   = r_idx + 25'd1;
                n_state = ess_pkg::S_OUT;
            end
            ess_pkg::S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid  = 1'b1;
                    n_osample = r_res;
                    n_olast   = r_rlast;
                    n_odone   = r_rdone;
                    n_state   = ess_pkg::S_IDLE;
                end
            end
            default: n_state = ess_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: tb/sweep_checker.sv
`timescale 1ns / 100ps
// Checker for the exponential sine sweep generator: predicts each sample and compares.
// Watches the config, request and result channels; depends on ess_pkg.
module sweep_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int TAB_DEPTH = 1024;
    localparam int IDX_BITS  = 24;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
        logic        done;
    } t_sweep_out;

    logic [31:0] sine_rom [0:TAB_DEPTH];
    t_sweep_out  expected_samples [$];

    logic [63:0] start_scale;
    logic [63:0] growth;
    logic [24:0] sweep_len;
    logic [18:0] fade_len;
    logic        fade_en;
    logic [1:0]  depth_mode;
    logic [63:0] q_acc;
    logic [24:0] idx;

    function automatic logic [63:0] fx60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [31:0] taylor_sine(input logic [63:0] x);
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] x2;
        logic [63:0] r;
        acc  = x;
        term = x;
        x2   = fx60_mul(x, x);
        for (int n = 1; n <= 9; n++) begin
            term = fx60_mul(term, x2) / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        r = (acc + 64'h1000_0000) >> 29;
        if (r > 64'h8000_0000) begin
            r = 64'h8000_0000;
        end
        return r[31:0];
    endfunction

    initial begin
        logic [63:0] qh;
        logic [63:0] rm;
        qh = ess_pkg::HALF_PI_Q60 / TAB_DEPTH;
        rm = ess_pkg::HALF_PI_Q60 % TAB_DEPTH;
        for (int k = 0; k <= TAB_DEPTH; k++) begin
            sine_rom[k] = taylor_sine(qh * 64'(k) + (rm * 64'(k)) / TAB_DEPTH);
        end
    end

    // Compute the next sample and, unless the sweep has ended, advance q and the index.
    function automatic t_sweep_out next_sample(input logic restart);
        t_sweep_out   res;
        logic         neg;
        logic [63:0]  d;
        logic [127:0] p;
        logic [31:0]  frac;
        logic [23:0]  pt;
        logic [1:0]   quad;
        logic [22:0]  off;
        logic [63:0]  addr;
        logic [31:0]  mag;
        int           bits;
        logic [31:0]  maxv;
        longint       s;
        longint       f;
        if (restart) begin
            q_acc = ess_pkg::Q48_ONE;
            idx   = '0;
        end
        res = '0;
        if (idx >= sweep_len) begin
            res.done = 1'b1;
            return res;
        end
        neg  = q_acc < ess_pkg::Q48_ONE;
        d    = neg ? ess_pkg::Q48_ONE - q_acc : q_acc - ess_pkg::Q48_ONE;
        p    = {64'd0, start_scale} * {64'd0, d};
        if (neg) begin
            p = -p;
        end
        frac = p[71:40];
        pt   = frac[31:32-IDX_BITS];
        quad = pt[23:22];
        off  = {1'b0, pt[21:0]};
        if (quad[0]) begin
            off = 23'h40_0000 - off;
        end
        addr = (64'(off) * TAB_DEPTH) >> (IDX_BITS - 2);
        if (addr > TAB_DEPTH) begin
            addr = TAB_DEPTH;
        end
        mag  = sine_rom[addr];
        bits = depth_mode == ess_pkg::MODE_16 ? 16 :
               (depth_mode == ess_pkg::MODE_24 ? 24 : 32);
        mag  = mag >> (32 - bits);
        maxv = (32'd1 << (bits - 1)) - 1;
        if (mag > maxv) begin
            mag = maxv;
        end
        s = quad[1] ? -longint'(mag) : longint'(mag);
        if (fade_en && fade_len != 0) begin
            f = longint'(fade_len);
            if (idx < fade_len) begin
                s = s * longint'(idx) / f;
            end
            if (longint'(idx) + f >= longint'(sweep_len)) begin
                s = s * (longint'(sweep_len) - 1 - longint'(idx)) / f;
            end
        end
        res.sample = s[31:0];
        res.last   = (idx == sweep_len - 1);
        p = {64'd0, q_acc} * {64'd0, growth};
        q_acc = (p[127:112] != 0) ? '1 : p[111:48];
        idx   = idx + 1;
        return res;
    endfunction

    assign o_pending = expected_samples.size();

    always @(posedge i_clk) begin
        t_sweep_out want;
        if (!i_rst_n) begin
            start_scale <= '0;
            growth      <= ess_pkg::Q48_ONE;
            sweep_len   <= 25'd48000;
            fade_len    <= 19'd960;
            fade_en     <= 1'b0;
            depth_mode  <= ess_pkg::MODE_16;
            q_acc       <= ess_pkg::Q48_ONE;
            idx         <= '0;
            o_errors    <= 0;
            expected_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ess_pkg::CFG_START_SCALE: start_scale = i_cfg_data;
                    ess_pkg::CFG_GROWTH:      growth      = i_cfg_data;
                    ess_pkg::CFG_SWEEP_LEN:   sweep_len   = i_cfg_data[24:0];
                    ess_pkg::CFG_FADE_LEN:    fade_len    = i_cfg_data[18:0];
                    ess_pkg::CFG_FADE_EN:     fade_en     = i_cfg_data[0];
                    ess_pkg::CFG_DEPTH_MODE:  depth_mode  = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                want = next_sample(i_s_tdata[0]);
                expected_samples = {expected_samples, want};
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result sample=%h last=%b done=%b", $time,
                             i_m_tdata, i_m_tlast, i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_samples.pop_front();
                    if (want.sample !== i_m_tdata || want.last !== i_m_tlast
                            || want.done !== i_m_tuser) begin
                        $display("%0t: mismatch expected sample=%h last=%b done=%b, got %h %b %b",
                                 $time, want.sample, want.last, want.done,
                                 i_m_tdata, i_m_tlast, i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the sweep generator testbench: clock, reset, configuration and requests.
// Instantiates exponential_sine_sweep_generator and sweep_checker; uses ess_pkg.
module testbench;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN      = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_last;
    logic        m_user;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          quiet_rx = 1'b0;
    bit          quiet_tx = 1'b0;
    int          sent = 0;

    always #4 i_clk = ~i_clk;

    exponential_sine_sweep_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tlast(m_last), .o_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sweep_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tlast(m_last), .i_m_tuser(m_user),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, with stall-free stretches.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) == 0) quiet_rx = ~quiet_rx;
            stall = quiet_rx ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready = 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Drain all results and let the block settle before touching registers.
    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic program_sweep(input logic [63:0] scale, input logic [63:0] ratio,
                                 input logic [24:0] len, input logic [18:0] fade,
                                 input logic fade_on, input logic [1:0] mode);
        wait_drained();
        write_reg(ess_pkg::CFG_START_SCALE, scale);
        write_reg(ess_pkg::CFG_GROWTH, ratio);
        write_reg(ess_pkg::CFG_SWEEP_LEN, {$urandom, 7'd0, len});
        write_reg(ess_pkg::CFG_FADE_LEN, {$urandom, 13'd0, fade});
        write_reg(ess_pkg::CFG_FADE_EN, {63'd0, fade_on});
        write_reg(ess_pkg::CFG_DEPTH_MODE, {62'd0, mode});
    endtask

    task automatic send_request(input logic restart);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 19);
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = {7'd0, restart};
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        s_valid = 1'b0;
        sent++;
    endtask

    initial begin
        logic [63:0] scale;
        logic [63:0] ratio;
        logic [24:0] len;
        logic [18:0] fade;
        int          count;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults after reset, then restart.
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);

        // Short faded sweep run past its end, then restarted.
        program_sweep(64'h0000_1234_5600_0000, ess_pkg::Q48_ONE + 64'h0000_0123_4567_89AB,
                      25'd6, 19'd3, 1'b1, ess_pkg::MODE_16);
        for (int k = 0; k < 8; k++) send_request(k == 7);
        // Sweep length zero: always done.
        program_sweep('1, '1, 25'd0, 19'd0, 1'b0, ess_pkg::MODE_UNUSED);
        send_request(1'b1);
        send_request(1'b0);
        // Extremes: growth overflow and growth below one.
        program_sweep('1, '1, 25'd16777216, 19'd335544, 1'b1, ess_pkg::MODE_24);
        for (int k = 0; k < 4; k++) send_request(k == 0);
        program_sweep('1, 64'd0, 25'd5, 19'd335544, 1'b1, ess_pkg::MODE_32);
        for (int k = 0; k < 5; k++) send_request(k == 0);

        while (sent < 950) begin
            case ($urandom_range(0, 5))
                0: scale = '1;
                1: scale = '0;
                default: scale = {$urandom, $urandom} >> $urandom_range(0, 40);
            endcase
            case ($urandom_range(0, 7))
                0: ratio = '1;
                1: ratio = '0;
                2: ratio = ess_pkg::Q48_ONE - ({$urandom, $urandom} >> $urandom_range(18, 60));
                3: ratio = {$urandom, $urandom};
                default: ratio = ess_pkg::Q48_ONE
                                 + ({$urandom, $urandom} >> $urandom_range(18, 60));
            endcase
            case ($urandom_range(0, 9))
                0: len = 25'd16777216;
                1: len = 25'd0;
                2: len = $urandom;
                default: len = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 4))
                0: fade = 19'd335544;
                1: fade = $urandom;
                default: fade = $urandom_range(0, 20);
            endcase
            program_sweep(scale, ratio, len, fade, $urandom_range(0, 1),
                          $urandom_range(0, 3));
            quiet_tx = ($urandom_range(0, 3) == 0);
            count = $urandom_range(30, 90);
            for (int k = 0; k < count; k++) send_request(k == 0 || $urandom_range(0, 24) == 0);
        end

        wait_drained();
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
design/ess_pkg.sv
design/exponential_sine_sweep_generator.sv
tb/sweep_checker.sv
tb/testbench.sv
